FILE: hdl/lpae_pkg.sv
// Shared types, codes and index helper for the long-descriptor table walker.
`timescale 1ns / 1ps

package lpae_pkg;

   // Widths fixed by the transaction fields
   localparam int unsigned PA_WIDTH   = 40;
   localparam int unsigned VA_WIDTH   = 32;
   localparam int unsigned DESC_WIDTH = 64;
   localparam int unsigned IDX_WIDTH  = 9;

   // Operation codes
   localparam logic OP_START      = 1'b0;
   localparam logic OP_DESCRIPTOR = 1'b1;

   // Configuration register indexes
   localparam logic CSR_TABLE_BASE  = 1'b0;
   localparam logic CSR_START_LEVEL = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_MAP   = 2'd1;
   localparam logic [1:0] KIND_FAULT = 2'd2;

   // Mapping sizes
   localparam logic [1:0] SIZE_4K = 2'd0;
   localparam logic [1:0] SIZE_2M = 2'd1;
   localparam logic [1:0] SIZE_1G = 2'd2;

   // Walk state: idle, or the level whose descriptor is awaited
   localparam logic [1:0] LEVEL_IDLE = 2'd0;
   localparam logic [1:0] LEVEL_1    = 2'd1;
   localparam logic [1:0] LEVEL_2    = 2'd2;
   localparam logic [1:0] LEVEL_3    = 2'd3;

   // Descriptor type field, bits 1:0
   localparam logic [1:0] DESC_BLOCK = 2'd1;
   localparam logic [1:0] DESC_TABLE = 2'd3;

   // One result transaction plus its presence flag
   typedef struct packed {
      logic                valid;
      logic [1:0]          kind;
      logic [PA_WIDTH-1:0] address;
      logic [1:0]          size_code;
      logic [6:0]          upper_attrs;
      logic [9:0]          lower_attrs;
   } lpae_result_type;

   // Table index of the virtual address at a given level, zero-extended
   function automatic logic [IDX_WIDTH-1:0] level_index(input logic [1:0] level,
                                                       input logic [VA_WIDTH-1:0] va);
      logic [IDX_WIDTH-1:0] idx;
      unique case (level)
         LEVEL_1: idx = {7'd0, va[31:30]};
         LEVEL_2: idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

   // Descriptor read address: base bits 39:5 with the index times eight
   function automatic logic [PA_WIDTH-1:0] read_address(input logic [PA_WIDTH-1:0] base,
                                                       input logic [IDX_WIDTH-1:0] idx);
      return {base[39:5], 5'd0} | {28'd0, idx, 3'd0};
   endfunction

endpackage

FILE: hdl/lpae_walk_core.sv
// Walk state and the one-level step logic of the table walker.
`timescale 1ns / 1ps

module lpae_walk_core import lpae_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic                  operation,
   input  logic [VA_WIDTH-1:0]   vaddr,
   input  logic [DESC_WIDTH-1:0] descriptor,
   input  logic                  read_failed,
   input  logic [PA_WIDTH-1:0]   table_base,
   input  logic [1:0]            start_level,
   output lpae_result_type       result
);

   logic [1:0]          walk_level_ff, walk_level_in;
   logic [VA_WIDTH-1:0] saved_vaddr_ff, saved_vaddr_in;
   logic [1:0]          first_level;
   logic [1:0]          desc_type;
   logic [1:0]          next_level;

   assign first_level = (start_level == LEVEL_1) ? LEVEL_1 : LEVEL_2;
   assign desc_type   = descriptor[1:0];
   assign next_level  = walk_level_ff + 2'd1;

   // Decode one transaction against the current walk state
   always_comb begin
      walk_level_in  = walk_level_ff;
      saved_vaddr_in = saved_vaddr_ff;
      result         = '0;
      if (operation == OP_START) begin
         saved_vaddr_in = vaddr;
         walk_level_in  = first_level;
         result.valid   = 1'b1;
         result.kind    = KIND_READ;
         result.address = read_address(table_base, level_index(first_level, vaddr));
      end else if (walk_level_ff != LEVEL_IDLE) begin
         walk_level_in = LEVEL_IDLE;
         result.valid  = 1'b1;
         result.kind   = KIND_FAULT;
         priority if (read_failed) begin
            result.kind = KIND_FAULT;
         end else if (walk_level_ff == LEVEL_3) begin
            if (desc_type == DESC_TABLE) begin
               result.kind        = KIND_MAP;
               result.address     = {descriptor[39:12], saved_vaddr_ff[11:0]};
               result.size_code   = SIZE_4K;
               result.upper_attrs = descriptor[58:52];
               result.lower_attrs = descriptor[11:2];
            end
         end else if (desc_type == DESC_BLOCK) begin
            result.kind        = KIND_MAP;
            result.upper_attrs = descriptor[58:52];
            result.lower_attrs = descriptor[11:2];
            if (walk_level_ff == LEVEL_1) begin
               result.address   = {descriptor[39:30], saved_vaddr_ff[29:0]};
               result.size_code = SIZE_1G;
            end else begin
               result.address   = {descriptor[39:21], saved_vaddr_ff[20:0]};
               result.size_code = SIZE_2M;
            end
         end else if (desc_type == DESC_TABLE) begin
            walk_level_in  = next_level;
            result.kind    = KIND_READ;
            result.address = read_address({descriptor[39:12], 12'd0},
                                          level_index(next_level, saved_vaddr_ff));
         end else begin
            // invalid or reserved type at level 1 or 2
            result.kind = KIND_FAULT;
         end
      end
   end

   // Walk state advances once per processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_level_ff  <= LEVEL_IDLE;
         saved_vaddr_ff <= '0;
      end else if (step_en) begin
         walk_level_ff  <= walk_level_in;
         saved_vaddr_ff <= saved_vaddr_in;
      end
   end

endmodule

FILE: hdl/lpae_page_table_walker.sv
// Top level of the long-descriptor page table walker.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    operation, vaddr, descriptor, read_failed
//   rsp      out        rsp_valid/stall    kind, address, size_code, upper/lower_attrs
//   csr      in         csr_write          csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp is not stalled; a taken request
// passes from the input register through the step logic into the result register,
// which offers the result (input register, step logic, result register).
// Reset clears the walk to idle, table_base to zero and start_level to one.
// A stall on rsp holds the result register and backs up into the input
// register; req_stall rises only when both are full.
`timescale 1ns / 1ps

module lpae_page_table_walker import lpae_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [VA_WIDTH-1:0]   req_vaddr,
   input  logic [DESC_WIDTH-1:0] req_descriptor,
   input  logic                  req_read_failed,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [PA_WIDTH-1:0]   rsp_address,
   output logic [1:0]            rsp_size_code,
   output logic [6:0]            rsp_upper_attrs,
   output logic [9:0]            rsp_lower_attrs,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [PA_WIDTH-1:0]   csr_wdata
);

   logic [PA_WIDTH-1:0]   table_base_ff;
   logic [1:0]            start_level_ff;
   logic                  in_valid_ff;
   logic                  in_operation_ff;
   logic [VA_WIDTH-1:0]   in_vaddr_ff;
   logic [DESC_WIDTH-1:0] in_descriptor_ff;
   logic                  in_read_failed_ff;
   logic                  rsp_valid_ff;
   lpae_result_type       rsp_data_ff;
   lpae_result_type       step_result;
   logic                  out_free;
   logic                  step_en;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff  <= '0;
         start_level_ff <= LEVEL_1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TABLE_BASE:  table_base_ff  <= csr_wdata;
            CSR_START_LEVEL: start_level_ff <= csr_wdata[1:0];
            default:         table_base_ff  <= table_base_ff;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_operation_ff   <= req_operation;
         in_vaddr_ff       <= req_vaddr;
         in_descriptor_ff  <= req_descriptor;
         in_read_failed_ff <= req_read_failed;
      end
   end

   lpae_walk_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .operation   (in_operation_ff),
      .vaddr       (in_vaddr_ff),
      .descriptor  (in_descriptor_ff),
      .read_failed (in_read_failed_ff),
      .table_base  (table_base_ff),
      .start_level (start_level_ff),
      .result      (step_result)
   );

   // Result register; a descriptor arriving while idle leaves no transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step_en && step_result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_data_ff.kind;
   assign rsp_address     = rsp_data_ff.address;
   assign rsp_size_code   = rsp_data_ff.size_code;
   assign rsp_upper_attrs = rsp_data_ff.upper_attrs;
   assign rsp_lower_attrs = rsp_data_ff.lower_attrs;

endmodule

FILE: test/tb.sv
// Self-checking testbench for the long-descriptor page table walker.
`timescale 1ns / 1ps

module tb;
   import lpae_pkg::*;

   // Descriptor types that always fault
   localparam logic [1:0] DESC_INVALID  = 2'd0;
   localparam logic [1:0] DESC_RESERVED = 2'd2;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_ITEMS   = 175;

   // Walk predictor and the queue of results it expects
   class walk_scoreboard;
      logic [PA_WIDTH-1:0] table_base;
      logic [1:0]          start_level;
      logic [1:0]          walk_level;
      logic [VA_WIDTH-1:0] saved_vaddr;
      lpae_result_type     pending_walk_results[$];
      int unsigned         mismatches;
      int unsigned         read_count;
      int unsigned         map_count;
      int unsigned         fault_count;
      int unsigned         ignored_count;

      function new();
         table_base    = '0;
         start_level   = LEVEL_1;
         walk_level    = LEVEL_IDLE;
         saved_vaddr   = '0;
         mismatches    = 0;
         read_count    = 0;
         map_count     = 0;
         fault_count   = 0;
         ignored_count = 0;
      endfunction

      function void apply_register(logic idx, logic [PA_WIDTH-1:0] value);
         if (idx == CSR_TABLE_BASE)
            table_base = value;
         else
            start_level = value[1:0];
      endfunction

      // Descriptor fetch address for a level of the walk
      function logic [PA_WIDTH-1:0] fetch_address(logic [PA_WIDTH-1:0] base,
                                                  logic [1:0] level,
                                                  logic [VA_WIDTH-1:0] va);
         logic [IDX_WIDTH-1:0] idx;
         logic [PA_WIDTH-1:0]  offset;
         if (level == LEVEL_1)
            idx = IDX_WIDTH'(va[31:30]);
         else if (level == LEVEL_2)
            idx = va[29:21];
         else
            idx = va[20:12];
         offset = PA_WIDTH'(idx) << 3;
         return {base[39:5], 5'b0} | offset;
      endfunction

      // Advance the walk by one accepted transaction; returns 1 if a result is due
      function bit walk_step(logic op, logic [VA_WIDTH-1:0] va,
                             logic [DESC_WIDTH-1:0] desc, logic failed);
         lpae_result_type     res;
         logic [1:0]          lvl;
         logic [VA_WIDTH-1:0] sva;
         logic [1:0]          dtype;
         res       = '0;
         res.valid = 1'b1;
         lvl       = walk_level;
         sva       = saved_vaddr;
         dtype     = desc[1:0];
         if (op == OP_START) begin
            saved_vaddr = va;
            walk_level  = (start_level == LEVEL_1) ? LEVEL_1 : LEVEL_2;
            res.kind    = KIND_READ;
            res.address = fetch_address(table_base, walk_level, va);
         end else if (lvl == LEVEL_IDLE) begin
            ignored_count++;
            return 1'b0;
         end else begin
            walk_level = LEVEL_IDLE;
            if (failed)
               res.kind = KIND_FAULT;
            else if (lvl == LEVEL_3 && dtype == DESC_TABLE) begin
               res.kind      = KIND_MAP;
               res.address   = {desc[39:12], sva[11:0]};
               res.size_code = SIZE_4K;
            end else if (lvl != LEVEL_3 && dtype == DESC_BLOCK) begin
               res.kind = KIND_MAP;
               if (lvl == LEVEL_1) begin
                  res.address   = {desc[39:30], sva[29:0]};
                  res.size_code = SIZE_1G;
               end else begin
                  res.address   = {desc[39:21], sva[20:0]};
                  res.size_code = SIZE_2M;
               end
            end else if (lvl != LEVEL_3 && dtype == DESC_TABLE) begin
               walk_level  = lvl + 2'd1;
               res.kind    = KIND_READ;
               res.address = fetch_address({desc[39:12], 12'b0}, walk_level, sva);
            end else
               res.kind = KIND_FAULT;
            if (res.kind == KIND_MAP) begin
               res.upper_attrs = desc[58:52];
               res.lower_attrs = desc[11:2];
            end
         end
         case (res.kind)
            KIND_READ: read_count++;
            KIND_MAP:  map_count++;
            default:   fault_count++;
         endcase
         pending_walk_results.insert(pending_walk_results.size(), res);
         return 1'b1;
      endfunction

      // Compare one accepted result with the oldest expectation
      function void check_walk_result(logic [1:0] kind, logic [PA_WIDTH-1:0] address,
                                      logic [1:0] size_code, logic [6:0] upper,
                                      logic [9:0] lower);
         lpae_result_type exp;
         if (pending_walk_results.size() == 0) begin
            $error("unexpected result: kind %0d address %0h", kind, address);
            mismatches++;
            return;
         end
         exp = pending_walk_results.pop_front();
         if (kind !== exp.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", exp.kind, kind);
            mismatches++;
         end
         if (address !== exp.address) begin
            $error("address mismatch: expected %0h, actual %0h", exp.address, address);
            mismatches++;
         end
         if (size_code !== exp.size_code) begin
            $error("size_code mismatch: expected %0d, actual %0d", exp.size_code, size_code);
            mismatches++;
         end
         if (upper !== exp.upper_attrs) begin
            $error("upper_attrs mismatch: expected %0h, actual %0h", exp.upper_attrs, upper);
            mismatches++;
         end
         if (lower !== exp.lower_attrs) begin
            $error("lower_attrs mismatch: expected %0h, actual %0h", exp.lower_attrs, lower);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_operation;
   logic [VA_WIDTH-1:0]   req_vaddr;
   logic [DESC_WIDTH-1:0] req_descriptor;
   logic                  req_read_failed;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_kind;
   logic [PA_WIDTH-1:0]   rsp_address;
   logic [1:0]            rsp_size_code;
   logic [6:0]            rsp_upper_attrs;
   logic [9:0]            rsp_lower_attrs;
   logic                  csr_write;
   logic                  csr_index;
   logic [PA_WIDTH-1:0]   csr_wdata;

   walk_scoreboard sb;
   int unsigned    sender_idle_pct;
   int unsigned    receiver_stall_pct;
   int unsigned    cycle_count;
   int unsigned    settings_used;

   lpae_page_table_walker DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_vaddr       (req_vaddr),
      .req_descriptor  (req_descriptor),
      .req_read_failed (req_read_failed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_address     (rsp_address),
      .rsp_size_code   (rsp_size_code),
      .rsp_upper_attrs (rsp_upper_attrs),
      .rsp_lower_attrs (rsp_lower_attrs),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Result side: check accepted transactions, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_walk_result(rsp_kind, rsp_address, rsp_size_code,
                                 rsp_upper_attrs, rsp_lower_attrs);
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Present one request transaction and hold it until accepted
   task automatic send_item(logic op, logic [VA_WIDTH-1:0] va,
                            logic [DESC_WIDTH-1:0] desc, logic failed, output bit produced);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_vaddr       <= va;
      req_descriptor  <= desc;
      req_read_failed <= failed;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      produced = sb.walk_step(op, va, desc, failed);
   endtask

   task automatic send(logic op, logic [VA_WIDTH-1:0] va,
                       logic [DESC_WIDTH-1:0] desc, logic failed);
      bit produced;
      send_item(op, va, desc, failed, produced);
   endtask

   // Sender gaps between transactions
   task automatic sender_gap();
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Let the pipeline empty before touching registers
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_walk_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [PA_WIDTH-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.apply_register(idx, value);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [PA_WIDTH-1:0] base, logic [1:0] level);
      logic [PA_WIDTH-1:0] level_word;
      // upper bits of the level word carry noise; only bits 1:0 are kept
      level_word = PA_WIDTH'({$urandom, $urandom});
      level_word[1:0] = level;
      write_register(CSR_TABLE_BASE, base);
      write_register(CSR_START_LEVEL, level_word);
      settings_used++;
   endtask

   function automatic logic [1:0] faulting_type();
      case ($urandom_range(1))
         0:       return DESC_INVALID;
         default: return DESC_RESERVED;
      endcase
   endfunction

   // One random transaction, shaped by where the walk currently stands
   task automatic random_transaction(output bit produced);
      logic [DESC_WIDTH-1:0] desc;
      logic [VA_WIDTH-1:0]   va;
      int unsigned           roll;
      desc = {$urandom, $urandom};
      va   = $urandom;
      roll = $urandom_range(99);
      if (sb.walk_level == LEVEL_IDLE) begin
         if (roll < 88)
            send_item(OP_START, va, desc, 1'($urandom_range(1)), produced);
         else
            send_item(OP_DESCRIPTOR, va, desc, 1'($urandom_range(1)), produced);
      end else if (roll < 5) begin
         // abandon the walk in progress
         send_item(OP_START, va, desc, 1'($urandom_range(1)), produced);
      end else if (roll < 10) begin
         send_item(OP_DESCRIPTOR, va, desc, 1'b1, produced);
      end else begin
         roll = $urandom_range(99);
         if (sb.walk_level == LEVEL_3) begin
            if (roll < 80)
               desc[1:0] = DESC_TABLE;
            else if (roll < 90)
               desc[1:0] = DESC_BLOCK;
            else
               desc[1:0] = faulting_type();
         end else if (roll < 60)
            desc[1:0] = DESC_TABLE;
         else if (roll < 88)
            desc[1:0] = DESC_BLOCK;
         else
            desc[1:0] = faulting_type();
         send_item(OP_DESCRIPTOR, va, desc, 1'b0, produced);
      end
   endtask

   // Main sequence
   initial begin
      bit          produced;
      int unsigned phase;
      int unsigned useful;
      int unsigned total_useful;
      logic [PA_WIDTH-1:0] bases[6];
      logic [1:0]          levels[6];

      sb                 = new();
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_operation      = OP_START;
      req_vaddr          = '0;
      req_descriptor     = '0;
      req_read_failed    = 1'b0;
      csr_write          = 1'b0;
      csr_index          = CSR_TABLE_BASE;
      csr_wdata          = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      settings_used      = 0;
      total_useful       = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset defaults first (base 0, start at level 1)
      send(OP_START, 32'h0000_0000, '0, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'h3FFF_FFFF_FFFF_FFFF, DESC_TABLE}, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'h0, DESC_TABLE}, 1'b0);
      send(OP_DESCRIPTOR, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      // 1G block with every descriptor bit above the type field set
      send(OP_START, 32'hFFFF_FFFF, '0, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'h3FFF_FFFF_FFFF_FFFF, DESC_BLOCK}, 1'b0);
      // 2M block, checks the 21-bit split
      send(OP_START, 32'h7FFF_FFFF, '0, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'h0, DESC_TABLE}, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'h3FFF_FFFF_FFFF_FFFF, DESC_BLOCK}, 1'b0);
      // descriptor while idle is dropped
      send(OP_DESCRIPTOR, '0, {62'h1234_5678, DESC_TABLE}, 1'b0);
      // new request abandons a walk; descriptor and failure ignored on a request
      send(OP_START, 32'h8020_1000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send(OP_START, 32'hC03F_F000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      // failed read faults even on a valid table descriptor
      send(OP_DESCRIPTOR, '0, {62'h3FFF_FFFF_FFFF_FFFF, DESC_TABLE}, 1'b1);
      // faulting types at level 1, and a block descriptor at level 3
      send(OP_START, 32'h4000_0000, '0, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'h55, DESC_INVALID}, 1'b0);
      send(OP_START, 32'h4000_0000, '0, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'hAA, DESC_RESERVED}, 1'b0);
      send(OP_START, 32'h0000_0FFF, '0, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'h3, DESC_TABLE}, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'h3, DESC_TABLE}, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'h3FFF_FFFF_FFFF_FFFF, DESC_BLOCK}, 1'b0);
      // failed read at level 3
      send(OP_START, 32'h0000_0000, '0, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'h0, DESC_TABLE}, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'h0, DESC_TABLE}, 1'b0);
      send(OP_DESCRIPTOR, '0, {62'h3FFF_FFFF_FFFF_FFFF, DESC_TABLE}, 1'b1);
      drain();

      // Register settings for the random phases, extremes included
      bases[0]  = 40'hFF_FFFF_FFFF; levels[0] = 2'd1;
      bases[1]  = 40'h00_0000_0000; levels[1] = 2'd2;
      bases[2]  = PA_WIDTH'({$urandom, $urandom}); levels[2] = 2'd0;
      bases[3]  = 40'hFF_FFFF_FFFF; levels[3] = 2'd3;
      bases[4]  = PA_WIDTH'({$urandom, $urandom}); levels[4] = 2'd2;
      bases[5]  = PA_WIDTH'({$urandom, $urandom}); levels[5] = 2'd1;

      // Random phases: sender-light, receiver-light, then no idling
      for (phase = 0; phase < 6; phase++) begin
         configure(bases[phase], levels[phase]);
         sender_idle_pct    = (phase < 2) ? 17 : (phase < 4) ? 63 : 0;
         receiver_stall_pct = (phase < 2) ? 63 : (phase < 4) ? 17 : 0;
         useful = 0;
         while (useful < PHASE_ITEMS) begin
            random_transaction(produced);
            if (produced)
               useful++;
            sender_gap();
         end
         total_useful += useful;
         drain();
      end

      if (sb.pending_walk_results.size() != 0) begin
         $error("%0d expected results never arrived", sb.pending_walk_results.size());
         sb.mismatches++;
      end

      $display("Covered %0d walk transactions over %0d register settings plus defaults",
               total_useful, settings_used);
      $display("Results: %0d fetches, %0d mappings, %0d faults; %0d stray descriptors dropped",
               sb.read_count, sb.map_count, sb.fault_count, sb.ignored_count);
      if (sb.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
